// ----- src/eeprom_write_controller_top_assert.svh -----
// Assertion macros for the EEPROM write controller top level
`ifndef EEPROM_WRITE_CONTROLLER_TOP_ASSERT_SVH
`define EEPROM_WRITE_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define EEWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EEWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/eewc_pkg.sv -----
// Shared types and constants for the EEPROM write controller
package eewc_pkg;

  localparam int ADDR_BITS     = 10;
  localparam int STORE_DEPTH   = 1 << ADDR_BITS;
  localparam int ENABLE_WINDOW = 4;
  localparam int WIN_W         = $clog2(ENABLE_WINDOW + 1);
  localparam int CNT_W         = 16;
  localparam int CTL_W         = 6;
  localparam int CELL_ADDR_W   = 10;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 32;

  localparam int CTL_READ   = 0;
  localparam int CTL_PROG   = 1;
  localparam int CTL_MASTER = 2;

  localparam logic [CNT_W-1:0] ERASE_WRITE_RESET = 16'd54400;
  localparam logic [CNT_W-1:0] SINGLE_OP_RESET   = 16'd28800;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_CTL      = 3'd1,
    CMD_DATA     = 3'd2,
    CMD_ADDR_LO  = 3'd3,
    CMD_ADDR_HI  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_ERASE_WRITE = 2'd0,
    MODE_ERASE       = 2'd1,
    MODE_WRITE       = 2'd2,
    MODE_NONE        = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_ERASE_WRITE = 1'b0,
    REG_SINGLE_OP   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/eewc_ctrl.sv -----
// Sequencer for the EEPROM write controller: clear sweep and per-word steps
module eewc_ctrl
  import eewc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       ready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    ready      = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- src/eewc_dp.sv -----
// Datapath: CPU registers, program countdown, cell store and result register
module eewc_dp
  import eewc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       status,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata;

  logic [ADDR_BITS-1:0] clr_addr;
  logic [CNT_W-1:0]     ew_ticks, so_ticks;
  logic [CTL_W-1:0]     ctl, ctl_next;
  logic [CTL_W-1:0]     ctl_wr;
  logic [7:0]           data, data_next;
  logic [7:0]           addr_lo, addr_hi;
  logic [WIN_W-1:0]     win, win_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [ADDR_BITS-1:0] paddr, paddr_next;
  logic [7:0]           pval, pval_next;
  logic                 ctl_written;
  logic                 halt, commit;
  logic [ADDR_BITS-1:0] addr;
  logic [2:0]           in_cmd;
  logic [7:0]           in_val;
  logic [CNT_W-1:0]     ew_eff, so_eff;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [7:0]           mem_wdata;

  assign in_cmd = in_data[2:0];
  assign in_val = in_data[10:3];
  assign addr   = ADDR_BITS'({addr_hi, addr_lo});
  assign ew_eff = (ew_ticks == '0) ? CNT_W'(1) : ew_ticks;
  assign so_eff = (so_ticks == '0) ? CNT_W'(1) : so_ticks;

  assign status.clear_last = (clr_addr == '1);
  assign status.out_free   = !out_valid || out_ready;

  // store: clear sweep, commit write, registered read
  assign mem_we    = cmd.clear || (cmd.exec && commit);
  assign mem_waddr = cmd.clear ? clr_addr : paddr;
  assign mem_wdata = cmd.clear ? 8'hFF : pval;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.fetch) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ew_ticks <= ERASE_WRITE_RESET;
      so_ticks <= SINGLE_OP_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_ERASE_WRITE) begin
        ew_ticks <= cfg_data;
      end
      if (cfg_index == REG_SINGLE_OP) begin
        so_ticks <= cfg_data;
      end
    end
  end

  // control write: program enable held while counting
  always_comb begin
    ctl_wr = in_val[CTL_W-1:0];
    if (cnt != '0) begin
      ctl_wr[CTL_PROG] = 1'b1;
    end
  end

  // controller tick
  always_comb begin
    ctl_next   = ctl;
    data_next  = data;
    win_next   = win;
    cnt_next   = cnt;
    paddr_next = paddr;
    pval_next  = pval;
    halt       = 1'b0;
    commit     = 1'b0;
    if (win != '0) begin
      win_next = win - 1'b1;
      if (win_next == '0) begin
        ctl_next[CTL_MASTER] = 1'b0;
      end
    end
    if (ctl_next[2:0] != '0) begin
      if (ctl_written && ctl_next[CTL_MASTER]) begin
        win_next = WIN_W'(ENABLE_WINDOW);
      end
      if (cnt != '0) begin
        ctl_next[CTL_PROG] = 1'b1;
        cnt_next = cnt - 1'b1;
        if (cnt_next == '0) begin
          ctl_next[CTL_PROG] = 1'b0;
          commit = 1'b1;
        end
      end else if (ctl_next[CTL_PROG] && !ctl_next[CTL_MASTER]) begin
        ctl_next[CTL_PROG] = 1'b0;
      end else begin
        if (ctl_next[CTL_PROG]) begin
          case (mode_t'(ctl_next[5:4]))
            MODE_ERASE_WRITE: begin
              cnt_next   = ew_eff;
              paddr_next = addr;
              pval_next  = data;
            end
            MODE_ERASE: begin
              cnt_next   = so_eff;
              paddr_next = addr;
              pval_next  = 8'hFF;
            end
            MODE_WRITE: begin
              cnt_next   = so_eff;
              paddr_next = addr;
              pval_next  = data & rdata;
            end
            default: begin
            end
          endcase
        end
        if (ctl_next[CTL_READ]) begin
          ctl_next[CTL_READ] = 1'b0;
          data_next = rdata;
          halt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl         <= '0;
      data        <= '0;
      addr_lo     <= '0;
      addr_hi     <= '0;
      win         <= '0;
      cnt         <= '0;
      paddr       <= '0;
      pval        <= '0;
      ctl_written <= 1'b0;
    end else if (cmd.accept) begin
      ctl_written <= (in_cmd == CMD_CTL);
      case (in_cmd)
        CMD_CTL:     ctl     <= ctl_wr;
        CMD_DATA:    data    <= in_val;
        CMD_ADDR_LO: addr_lo <= in_val;
        CMD_ADDR_HI: addr_hi <= in_val;
        default: begin
        end
      endcase
    end else if (cmd.exec) begin
      ctl   <= ctl_next;
      data  <= data_next;
      win   <= win_next;
      cnt   <= cnt_next;
      paddr <= paddr_next;
      pval  <= pval_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data <= {6'd0, (cnt_next != '0), halt, CELL_ADDR_W'(addr), data_next, ctl_next};
    end
  end

endmodule

// ----- src/eeprom_write_controller_top.sv -----
// Top level of the EEPROM write controller
//
//  channel  | direction | contents
//  s_axis   | in        | one tick: cmd, write_value
//  m_axis   | out       | state after the tick: control, data, address, halt, busy
//  cfg      | in        | tick counts for erase+write and single operations
//
// Each word goes through accept, store read, then controller tick and result load.
// After reset every cell of the store is swept to 0xFF; no word is accepted then.
// A result waiting in the output register stalls the tick step, not the accept.
// Configuration writes are taken in any cycle out of reset, the sweep included.
module eeprom_write_controller_top
  import eewc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // cmd[2:0], write_value[10:3]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // control_value[5:0], data_value[13:6],
                                      // cell_address[23:14], halt_request[24], busy_res[25]
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  eewc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .cmd      (cmd),
    .ready    (s_tready)
  );

  eewc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

`include "eeprom_write_controller_top_assert.svh"

  `EEWC_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !s_tready, "word accepted during clear")
  `EEWC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second word too early")
  `EEWC_ASSERT_NOW(a_busy_has_prog, m_tvalid && m_tdata[25], m_tdata[1], "busy without program bit")
  `EEWC_ASSERT_NOW(a_halt_clears_read, m_tvalid && m_tdata[24], !m_tdata[0], "read bit left after halt")

endmodule
